FILE: hdl/tsm_pkg.sv
package tsm_pkg;

  localparam int NUM_SAMPLES_DEF = 10;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int RANK_LO  = 3;
  localparam int RANK_MID = 4;
  localparam int RANK_HI  = 5;

endpackage

FILE: hdl/tsm_if.sv
interface tsm_in_if
  import tsm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] x_sample;
  logic [SAMPLE_BITS-1:0] y_sample;

  modport source (output valid, output x_sample, output y_sample, input ready);
  modport sink   (input valid, input x_sample, input y_sample, output ready);
endinterface

interface tsm_out_if
  import tsm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] x_filtered;
  logic [SAMPLE_BITS-1:0] y_filtered;

  modport source (output valid, output x_filtered, output y_filtered, input ready);
  modport sink   (input valid, input x_filtered, input y_filtered, output ready);
endinterface

FILE: hdl/tsm_cell.sv
module tsm_cell
  import tsm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic                   valid,
  input  logic [SAMPLE_BITS-1:0] d,
  input  logic [SAMPLE_BITS-1:0] left_val,
  input  logic                   left_gt,
  output logic [SAMPLE_BITS-1:0] val_o,
  output logic                   gt_o
);

  logic [SAMPLE_BITS-1:0] val_r;
  logic                   take_d;

  // gt: this cell holds a larger value and moves one place right
  assign gt_o   = valid && (val_r > d);
  assign take_d = !left_gt && (gt_o || !valid);
  assign val_o  = val_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (left_gt) begin
        val_r <= left_val;
      end else if (take_d) begin
        val_r <= d;
      end
    end
  end

endmodule

FILE: hdl/tsm_chain.sv
module tsm_chain
  import tsm_pkg::*;
#(
  parameter int NUM_SAMPLES = NUM_SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int CNT_W      = $clog2(NUM_SAMPLES)
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [CNT_W-1:0]       count,
  input  logic [SAMPLE_BITS-1:0] d,
  output logic [SAMPLE_BITS-1:0] rank_lo,
  output logic [SAMPLE_BITS-1:0] rank_mid,
  output logic [SAMPLE_BITS-1:0] rank_hi
);

  logic [SAMPLE_BITS-1:0] val [NUM_SAMPLES];
  logic                   gt  [NUM_SAMPLES];

  for (genvar i = 0; i < NUM_SAMPLES; i++) begin : g_cell
    logic                   cell_valid;
    logic [SAMPLE_BITS-1:0] left_val;
    logic                   left_gt;

    assign cell_valid = CNT_W'(i) < count;

    if (i == 0) begin : g_head
      assign left_val = d;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_val = val[i-1];
      assign left_gt  = gt[i-1];
    end

    tsm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk      (clk),
      .en       (en),
      .valid    (cell_valid),
      .d        (d),
      .left_val (left_val),
      .left_gt  (left_gt),
      .val_o    (val[i]),
      .gt_o     (gt[i])
    );
  end

  assign rank_lo  = val[RANK_LO];
  assign rank_mid = val[RANK_MID];
  assign rank_hi  = val[RANK_HI];

endmodule

FILE: hdl/tsm_div3.sv
module tsm_div3
  import tsm_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int SUM_W      = SAMPLE_BITS + 2
) (
  input  logic                   clk,
  input  logic [SUM_W-1:0]       sum_i,
  output logic [SAMPLE_BITS-1:0] q_o
);

  localparam int PROD_W = 2 * SUM_W;
  localparam logic [SUM_W-1:0] DIV_M = SUM_W'((64'd1 << SUM_W) / 64'd3);

  logic [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]  sum_d_r;
  logic [SUM_W-1:0]  q0;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  q;

  always_ff @(posedge clk) begin
    prod_r  <= PROD_W'(sum_i) * PROD_W'(DIV_M);
    sum_d_r <= sum_i;
  end

  // reciprocal estimate is low by at most one
  always_comb begin
    q0  = prod_r[PROD_W-1:SUM_W];
    rem = sum_d_r - ((q0 << 1) + q0);
    q   = (rem >= SUM_W'(3)) ? q0 + SUM_W'(1) : q0;
  end

  assign q_o = q[SAMPLE_BITS-1:0];

endmodule

FILE: hdl/touch_sample_trimmed_mean_unit.sv
// Takes one X/Y pair per cycle while ready; pairs are insertion-sorted into two cell rows.
// The result of a set passes sort, sum, multiply and correct registers after its last pair.
// A set of NUM_SAMPLES pairs gives one result word.
// The last pair of a set waits while the previous result is in flight or not yet taken.
// Reset clears the pair count and the pipeline valid flags; sample cells are not reset.
module touch_sample_trimmed_mean_unit
  import tsm_pkg::*;
#(
  parameter int NUM_SAMPLES = NUM_SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tsm_in_if.sink     in_w,
  tsm_out_if.source  out_w
);

  localparam int CNT_W = $clog2(NUM_SAMPLES);
  localparam int SUM_W = SAMPLE_BITS + 2;

  logic [CNT_W-1:0]       count_r, count_nxt, cnt_eff;
  logic                   last_pair;
  logic                   accept;
  logic                   busy;
  logic                   fin_r, sum_v_r, mul_v_r, out_valid_r;
  logic [SUM_W-1:0]       sum_x_r, sum_y_r;
  logic [SAMPLE_BITS-1:0] x_lo, x_mid, x_hi, y_lo, y_mid, y_hi;
  logic [SAMPLE_BITS-1:0] x_q, y_q;
  logic [SAMPLE_BITS-1:0] x_out_r, y_out_r;

  always_comb begin
    cnt_eff   = ({1'b0, count_r} >= (CNT_W+1)'(NUM_SAMPLES)) ? '0 : count_r;
    last_pair = cnt_eff == CNT_W'(NUM_SAMPLES - 1);
    count_nxt = last_pair ? '0 : cnt_eff + CNT_W'(1);
  end

  assign busy       = fin_r || sum_v_r || mul_v_r || out_valid_r;
  assign in_w.ready = !(last_pair && busy);
  assign accept     = in_w.valid && in_w.ready;

  tsm_chain #(
    .NUM_SAMPLES (NUM_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_chain_x (
    .clk      (clk),
    .en       (accept),
    .count    (cnt_eff),
    .d        (in_w.x_sample),
    .rank_lo  (x_lo),
    .rank_mid (x_mid),
    .rank_hi  (x_hi)
  );

  tsm_chain #(
    .NUM_SAMPLES (NUM_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_chain_y (
    .clk      (clk),
    .en       (accept),
    .count    (cnt_eff),
    .d        (in_w.y_sample),
    .rank_lo  (y_lo),
    .rank_mid (y_mid),
    .rank_hi  (y_hi)
  );

  tsm_div3 #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div_x (
    .clk   (clk),
    .sum_i (sum_x_r),
    .q_o   (x_q)
  );

  tsm_div3 #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div_y (
    .clk   (clk),
    .sum_i (sum_y_r),
    .q_o   (y_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      fin_r       <= 1'b0;
      sum_v_r     <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      fin_r   <= accept && last_pair;
      sum_v_r <= fin_r;
      mul_v_r <= sum_v_r;
      if (mul_v_r) begin
        out_valid_r <= 1'b1;
      end else if (out_w.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_r) begin
      sum_x_r <= SUM_W'(x_lo) + SUM_W'(x_mid) + SUM_W'(x_hi);
      sum_y_r <= SUM_W'(y_lo) + SUM_W'(y_mid) + SUM_W'(y_hi);
    end
    if (mul_v_r) begin
      x_out_r <= x_q;
      y_out_r <= y_q;
    end
  end

  assign out_w.valid      = out_valid_r;
  assign out_w.x_filtered = x_out_r;
  assign out_w.y_filtered = y_out_r;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({fin_r, sum_v_r, mul_v_r, out_valid_r}))
    else $error("more than one result in flight");

  a_last_starts_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_pair) |=> fin_r)
    else $error("last pair did not start result pipeline");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, count_r} < (CNT_W+1)'(NUM_SAMPLES))
    else $error("pair count out of range");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(mul_v_r))
    else $error("result word without pipeline source");

endmodule
